[rtl/core/tli_pkg.sv]
// Shared widths and defaults for the table linear interpolator.
`default_nettype none

package tli_pkg;

	localparam int TABLE_POINTS_DEF = 64;

	localparam int KEY_W  = 32;
	localparam int VAL_W  = 24;
	localparam int CFG_W  = 7;
	localparam int IDX_W  = 6;
	localparam int OUT_W  = 32;
	localparam int PROD_W = KEY_W + VAL_W;
	localparam int RES_W  = PROD_W + 3;

endpackage

`default_nettype wire

[rtl/core/tli_table.sv]
// Key and value point storage with one write port and one registered read port.
`default_nettype none

module tli_table #(
	parameter int TABLE_POINTS = tli_pkg::TABLE_POINTS_DEF,
	localparam int ADDR_W = $clog2(TABLE_POINTS)
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [ADDR_W-1:0]         wr_addr,
	input  wire logic [tli_pkg::KEY_W-1:0] wr_key,
	input  wire logic [tli_pkg::VAL_W-1:0] wr_val,
	input  wire logic [ADDR_W-1:0]         rd_addr,
	output logic      [tli_pkg::KEY_W-1:0] rd_key,
	output logic      [tli_pkg::VAL_W-1:0] rd_val
);

	logic [tli_pkg::KEY_W-1:0] key_mem [TABLE_POINTS];
	logic [tli_pkg::VAL_W-1:0] val_mem [TABLE_POINTS];
	logic [tli_pkg::KEY_W-1:0] rd_key_q;
	logic [tli_pkg::VAL_W-1:0] rd_val_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	assign rd_key = rd_key_q;
	assign rd_val = rd_val_q;

endmodule

`default_nettype wire

[rtl/core/tli_div.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module tli_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tli_pkg::PROD_W-1:0] dividend,
	input  wire logic [tli_pkg::KEY_W-1:0]  divisor,
	output logic                            done,
	output logic      [tli_pkg::PROD_W-1:0] quotient
);

	localparam int DVD_W = tli_pkg::PROD_W;
	localparam int DVS_W = tli_pkg::KEY_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             running_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_W'(DVD_W);
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (running_q) begin
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

[rtl/core/table_linear_interpolator.sv]
// Top level of the table linear interpolator: sequencer, datapath and output register.
//
// A write item stores one point. A query reads the table one entry per cycle
// from entry 0 until it finds the first pair of neighbors that brackets the
// query key, or falls back to the line through the first and last points in
// use, then forms the product of the offsets and divides it by the key span in
// a one-bit-per-cycle divider. The single read port of the table sets the scan
// length with the number of points in use, and the 56 quotient bits set the
// divide length. Queries with one point or with two equal keys skip the divide.
// The input is stalled while a query is at work; a finished result waits in the
// output register.
`default_nettype none

module table_linear_interpolator #(
	parameter int TABLE_POINTS = tli_pkg::TABLE_POINTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              operation,
	input  wire logic        [tli_pkg::IDX_W-1:0]  point_index,
	input  wire logic        [tli_pkg::KEY_W-1:0]  point_key,
	input  wire logic        [tli_pkg::VAL_W-1:0]  point_value,
	input  wire logic        [tli_pkg::KEY_W-1:0]  query_key,
	input  wire logic                              query_last,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed      [tli_pkg::OUT_W-1:0]  interpolated_value,
	output logic                                   extrapolated,
	output logic                                   saturated,
	output logic                                   last_result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic        [tli_pkg::CFG_W-1:0]  cfg_data
);

	localparam int ADDR_W = $clog2(TABLE_POINTS);
	localparam int CNT_W  = $clog2(TABLE_POINTS + 1);
	localparam int KEY_W  = tli_pkg::KEY_W;
	localparam int VAL_W  = tli_pkg::VAL_W;
	localparam int PROD_W = tli_pkg::PROD_W;
	localparam int RES_W  = tli_pkg::RES_W;
	localparam int OUT_W  = tli_pkg::OUT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_SETUP = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_LOAD  = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam logic signed [RES_W-1:0] SAT_HI = {{(RES_W-OUT_W){1'b0}}, 32'h7fff_ffff};
	localparam logic signed [RES_W-1:0] SAT_LO = {{(RES_W-OUT_W){1'b1}}, 32'h8000_0000};

	logic [2:0]                state_q;
	logic [tli_pkg::CFG_W-1:0] points_in_use_q;
	logic [CNT_W-1:0]          n_q;
	logic [ADDR_W-1:0]         idx_q;
	logic [KEY_W-1:0]          target_q;
	logic                      last_q;
	logic [KEY_W-1:0]          first_key_q;
	logic [VAL_W-1:0]          first_val_q;
	logic [KEY_W-1:0]          prev_key_q;
	logic [VAL_W-1:0]          prev_val_q;
	logic [KEY_W-1:0]          klo_q;
	logic [VAL_W-1:0]          vlo_q;
	logic [KEY_W-1:0]          khi_q;
	logic [VAL_W-1:0]          vhi_q;
	logic [KEY_W-1:0]          mag_dt_q;
	logic [VAL_W-1:0]          mag_dv_q;
	logic [KEY_W-1:0]          mag_dk_q;
	logic                      neg_q;
	logic                      use_div_q;
	logic                      extra_q;
	logic [PROD_W-1:0]         prod_q;

	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   out_value_q;
	logic                      out_extra_q;
	logic                      out_sat_q;
	logic                      out_last_q;

	logic                      in_accept;
	logic                      wr_en;
	logic [ADDR_W-1:0]         rd_addr;
	logic [KEY_W-1:0]          rd_key;
	logic [VAL_W-1:0]          rd_val;
	logic                      div_start;
	logic                      div_done;
	logic [PROD_W-1:0]         div_quot;
	logic [31:0]               n_full;
	logic                      bracket;
	logic                      scan_end;
	logic signed [KEY_W:0]     dt;
	logic signed [KEY_W:0]     dk;
	logic signed [VAL_W:0]     dv;
	logic [PROD_W-1:0]         quot_sel;
	logic signed [RES_W-1:0]   vlo_ext;
	logic signed [RES_W-1:0]   quot_ext;
	logic signed [RES_W-1:0]   res;
	logic                      res_hi;
	logic                      res_lo;
	logic                      out_free;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign wr_en     = in_accept && !operation && (32'(point_index) < TABLE_POINTS);

	tli_table #(
		.TABLE_POINTS(TABLE_POINTS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ADDR_W'(point_index)),
		.wr_key (point_key),
		.wr_val (point_value),
		.rd_addr(rd_addr),
		.rd_key (rd_key),
		.rd_val (rd_val)
	);

	tli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_q),
		.divisor (mag_dk_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	assign div_start = (state_q == ST_LOAD);

	always_comb begin
		unique case (state_q)
			ST_FIRST: rd_addr = ADDR_W'(1);
			ST_SCAN:  rd_addr = idx_q + 1'b1;
			default:  rd_addr = '0;
		endcase
	end

	always_comb begin
		if (points_in_use_q == '0) begin
			n_full = 32'd1;
		end else if (32'(points_in_use_q) > TABLE_POINTS) begin
			n_full = 32'(TABLE_POINTS);
		end else begin
			n_full = 32'(points_in_use_q);
		end
	end

	assign bracket  = (prev_key_q <= target_q) && (rd_key >= target_q);
	assign scan_end = (CNT_W'(idx_q) == n_q - 1'b1);

	assign dt = signed'({1'b0, target_q}) - signed'({1'b0, klo_q});
	assign dk = signed'({1'b0, khi_q}) - signed'({1'b0, klo_q});
	assign dv = signed'({1'b0, vhi_q}) - signed'({1'b0, vlo_q});

	assign quot_sel = use_div_q ? div_quot : '0;
	assign vlo_ext  = signed'({{(RES_W-VAL_W){1'b0}}, vlo_q});
	assign quot_ext = signed'({{(RES_W-PROD_W){1'b0}}, quot_sel});
	assign res      = neg_q ? (vlo_ext - quot_ext) : (vlo_ext + quot_ext);
	assign res_hi   = res > SAT_HI;
	assign res_lo   = res < SAT_LO;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_in_use_q <= tli_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			points_in_use_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && operation) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					state_q <= (n_q == CNT_W'(1)) ? ST_FIN : ST_SCAN;
				end
				ST_SCAN: begin
					if (bracket || scan_end) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= (dk == '0) ? ST_FIN : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && operation) begin
					n_q       <= CNT_W'(n_full);
					target_q  <= query_key;
					last_q    <= query_last;
					idx_q     <= '0;
					extra_q   <= 1'b0;
					use_div_q <= 1'b0;
					neg_q     <= 1'b0;
				end
			end
			ST_FIRST: begin
				first_key_q <= rd_key;
				first_val_q <= rd_val;
				prev_key_q  <= rd_key;
				prev_val_q  <= rd_val;
				vlo_q       <= rd_val;
				idx_q       <= ADDR_W'(1);
			end
			ST_SCAN: begin
				if (bracket) begin
					klo_q <= prev_key_q;
					vlo_q <= prev_val_q;
					khi_q <= rd_key;
					vhi_q <= rd_val;
				end else if (scan_end) begin
					klo_q   <= first_key_q;
					vlo_q   <= first_val_q;
					khi_q   <= rd_key;
					vhi_q   <= rd_val;
					extra_q <= 1'b1;
				end else begin
					prev_key_q <= rd_key;
					prev_val_q <= rd_val;
					idx_q      <= idx_q + 1'b1;
				end
			end
			ST_SETUP: begin
				mag_dt_q  <= dt[KEY_W] ? KEY_W'(-dt) : dt[KEY_W-1:0];
				mag_dk_q  <= dk[KEY_W] ? KEY_W'(-dk) : dk[KEY_W-1:0];
				mag_dv_q  <= dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0];
				neg_q     <= dt[KEY_W] ^ dk[KEY_W] ^ dv[VAL_W];
				use_div_q <= (dk != '0);
			end
			ST_MUL: begin
				prod_q <= PROD_W'(mag_dt_q) * PROD_W'(mag_dv_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			priority if (res_hi) begin
				out_value_q <= SAT_HI[OUT_W-1:0];
			end else if (res_lo) begin
				out_value_q <= SAT_LO[OUT_W-1:0];
			end else begin
				out_value_q <= res[OUT_W-1:0];
			end
			out_sat_q   <= res_hi || res_lo;
			out_extra_q <= extra_q;
			out_last_q  <= last_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign interpolated_value = out_value_q;
	assign extrapolated       = out_extra_q;
	assign saturated          = out_sat_q;
	assign last_result        = out_last_q;

endmodule

`default_nettype wire
